// ===== src/lrupr_pkg.sv =====
// Shared types and constants for the LRU page replacement core.
package lrupr_pkg;

	// Fixed field widths of one reference word and one result word.
	localparam int unsigned PAGE_W  = 15;
	localparam int unsigned FRAME_W = 6;
	localparam int unsigned COUNT_W = 16;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} lrupr_state_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic in_fire;
		logic scan_done;
		logic out_free;
	} lrupr_stat_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic in_ready;
		logic scan;
		logic commit;
	} lrupr_cmd_t;

endpackage

// ===== src/lrupr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lrupr_ram #(
	parameter int unsigned WIDTH = 15,
	parameter int unsigned DEPTH = 8,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/lrupr_ctrl.sv =====
// Sequencer that steps one reference through scan and update.
module lrupr_ctrl
	import lrupr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  lrupr_stat_t stat,
	output lrupr_cmd_t  cmd
);

	lrupr_state_t state_q;
	lrupr_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (stat.in_fire) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_UPDATE: begin
				cmd.commit = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== src/lru_page_replacement_core.sv =====
// Scan: a reference is scanned one frame per cycle, ending at the first hit or the last frame; its result word
// is registered on commit in update, and the next reference is taken only once the sequencer is back in idle.
// The single tag comparator walks the frame RAM one entry a cycle, so a reference is finished before the next
// is accepted. A stalled result word holds the core in update.
// Reset: all frames empty, recency order ascending (frame 0 oldest), fault count zero.
// The frame page RAM is not cleared; entries are only used once their valid bit is set.
module lru_page_replacement_core
	import lrupr_pkg::*;
#(
	parameter int unsigned FRAMES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [PAGE_W-1:0]  page,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic [FRAME_W-1:0] frame,
	output logic               evicted_valid,
	output logic [PAGE_W-1:0]  evicted_page,
	output logic [COUNT_W-1:0] fault_count
);

	localparam int unsigned IDXW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int unsigned CNTW = $clog2(FRAMES + 1);
	localparam logic [CNTW-1:0] SCAN_END = CNTW'(FRAMES);
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(FRAMES - 1);

	lrupr_stat_t stat;
	lrupr_cmd_t  cmd;

	logic [PAGE_W-1:0]  page_q;
	logic [CNTW-1:0]    rd_idx_q;
	logic               cmp_vld_s1;
	logic [IDXW-1:0]    cmp_idx_s1;
	logic               hit_q;
	logic [IDXW-1:0]    hit_frame_q;
	logic               empty_found_q;
	logic [IDXW-1:0]    empty_frame_q;
	logic [IDXW-1:0]    lru_frame_q;
	logic [PAGE_W-1:0]  lru_page_q;
	logic [FRAMES-1:0]  valid_q;
	logic [IDXW-1:0]    rank_q [FRAMES];
	logic [COUNT_W-1:0] faults_q;
	logic               out_valid_q;
	logic               hit_out_q;
	logic [FRAME_W-1:0] frame_out_q;
	logic               ev_valid_out_q;
	logic [PAGE_W-1:0]  ev_page_out_q;
	logic [COUNT_W-1:0] count_out_q;

	logic               in_fire;
	logic               rd_en;
	logic [PAGE_W-1:0]  rd_data;
	logic               cmp_active;
	logic               match_now;
	logic [IDXW-1:0]    sel_frame;
	logic               miss;
	logic               evict;
	logic [COUNT_W-1:0] faults_next;

	// Sequencer.
	lrupr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Page tag store, one entry per frame.
	lrupr_ram #(
		.WIDTH (PAGE_W),
		.DEPTH (FRAMES)
	) u_ram (
		.clk   (clk),
		.we    (cmd.commit && miss),
		.waddr (sel_frame),
		.wdata (page_q),
		.re    (rd_en),
		.raddr (rd_idx_q[IDXW-1:0]),
		.rdata (rd_data)
	);

	assign in_ready = cmd.in_ready;
	assign in_fire  = in_valid && cmd.in_ready;
	assign rd_en    = cmd.scan && (rd_idx_q != SCAN_END);

	// The shared comparator sees one frame per cycle, in the cycle after its read address.
	assign cmp_active = cmd.scan && cmp_vld_s1;
	assign match_now  = cmp_active && valid_q[cmp_idx_s1] && (rd_data == page_q);

	assign stat.in_fire   = in_fire;
	assign stat.scan_done = cmp_active && (match_now || (cmp_idx_s1 == LAST_IDX));
	assign stat.out_free  = !out_valid_q || out_ready;

	// Frame chosen for this reference and fault bookkeeping.
	assign miss        = !hit_q;
	assign evict       = miss && !empty_found_q;
	assign faults_next = miss ? (faults_q + COUNT_W'(1)) : faults_q;

	always_comb begin
		priority if (hit_q) begin
			sel_frame = hit_frame_q;
		end else if (empty_found_q) begin
			sel_frame = empty_frame_q;
		end else begin
			sel_frame = lru_frame_q;
		end
	end

	// Reference capture and scan address counter.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			page_q   <= page;
			rd_idx_q <= '0;
		end else if (rd_en) begin
			rd_idx_q <= rd_idx_q + CNTW'(1);
		end
		cmp_idx_s1 <= rd_idx_q[IDXW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
		end
	end

	// Scan results: matching frame, lowest empty frame, least recent frame and its page.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			hit_q         <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (cmp_active) begin
			if (match_now) begin
				hit_q       <= 1'b1;
				hit_frame_q <= cmp_idx_s1;
			end
			if (!valid_q[cmp_idx_s1] && !empty_found_q) begin
				empty_found_q <= 1'b1;
				empty_frame_q <= cmp_idx_s1;
			end
			if (rank_q[cmp_idx_s1] == '0) begin
				lru_frame_q <= cmp_idx_s1;
				lru_page_q  <= rd_data;
			end
		end
	end

	// Frame valid bits, recency ranks and the fault counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			faults_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= IDXW'(i);
			end
		end else if (cmd.commit) begin
			valid_q[sel_frame] <= 1'b1;
			faults_q           <= faults_next;
			for (int i = 0; i < FRAMES; i++) begin
				if (IDXW'(i) == sel_frame) begin
					rank_q[i] <= LAST_IDX;
				end else if (rank_q[i] > rank_q[sel_frame]) begin
					rank_q[i] <= rank_q[i] - IDXW'(1);
				end
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_out_q      <= hit_q;
			frame_out_q    <= FRAME_W'(sel_frame);
			ev_valid_out_q <= evict;
			ev_page_out_q  <= evict ? lru_page_q : '0;
			count_out_q    <= faults_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_out_q;
	assign frame         = frame_out_q;
	assign evicted_valid = ev_valid_out_q;
	assign evicted_page  = ev_page_out_q;
	assign fault_count   = count_out_q;

endmodule
